// ===== design/jtc_pkg.sv =====
// Shared types and constants for the jump table with cover query.
package jtc_pkg;

    localparam int BUCKETS  = 16;
    localparam int CAPACITY = 64;

    localparam int PTR_W  = 7;
    localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    localparam logic [PTR_W-1:0] NIL = '1;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_GET    = 2'd1;
    localparam logic [1:0] ACT_FIND   = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMATCH = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [BKT_W-1:0]  bkt_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] key;
        logic [15:0] jump_source;
        logic [15:0] jump_target;
        logic        backward;
    } jtc_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found_key;
        logic [15:0] found_source;
        logic [15:0] found_target;
        logic        found_backward;
        logic        last;
    } jtc_result_t;

    typedef struct packed {
        logic [15:0] key;
        logic [15:0] source;
        logic [15:0] target;
        logic        backward;
    } jtc_rec_t;

    typedef struct packed {
        jtc_rec_t rec;
        ptr_t     link;
    } jtc_entry_t;

    localparam int ENTRY_W = $bits(jtc_entry_t);

    typedef struct packed {
        logic we;
        bkt_t waddr;
        ptr_t wdata;
        bkt_t raddr;
    } head_cmd_t;

    typedef struct packed {
        logic       we;
        addr_t      waddr;
        jtc_entry_t wdata;
        addr_t      raddr;
    } entry_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_GET_HEAD,
        S_GET_ENT,
        S_FIND_HEAD,
        S_FIND_ENT,
        S_FIND_DONE
    } jtc_state_t;

endpackage

// ===== design/jtc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module jtc_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/jtc_heads.sv =====
// Bucket head table: RAM plus per-bucket valid bits so reset reads as null.
module jtc_heads (
    input  logic               clk,
    input  logic               rst_n,
    input  jtc_pkg::head_cmd_t head_cmd,
    output jtc_pkg::ptr_t      head_ptr
);
    import jtc_pkg::*;

    logic [BUCKETS-1:0] valid_reg;
    logic               rd_valid_reg;
    ptr_t               rdata;

    jtc_ram #(
        .DEPTH (BUCKETS),
        .WIDTH (PTR_W)
    ) u_ram (
        .clk   (clk),
        .we    (head_cmd.we),
        .waddr (head_cmd.waddr),
        .wdata (head_cmd.wdata),
        .raddr (head_cmd.raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (head_cmd.we)
            begin
                valid_reg[head_cmd.waddr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[head_cmd.raddr];
        end
    end

    assign head_ptr = rd_valid_reg ? rdata : NIL;

endmodule

// ===== design/jtc_ctrl.sv =====
// Sequencer: insert, chain walk for get, bucket-by-bucket scan for cover query.
module jtc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  jtc_pkg::jtc_cmd_t    cmd,
    output logic                 busy,
    output jtc_pkg::head_cmd_t   head_cmd,
    input  jtc_pkg::ptr_t        head_ptr,
    output jtc_pkg::entry_cmd_t  entry_cmd,
    input  jtc_pkg::jtc_entry_t  entry_rd,
    output logic                 strobe,
    output jtc_pkg::jtc_result_t result
);
    import jtc_pkg::*;

    jtc_state_t  state_reg, state_next;
    jtc_cmd_t    cmd_reg, cmd_next;
    cnt_t        count_reg, count_next;
    bkt_t        bkt_reg, bkt_next;
    logic        pend_valid_reg, pend_valid_next;
    jtc_rec_t    pend_reg, pend_next;
    logic        strobe_reg, strobe_next;
    jtc_result_t result_reg, result_next;

    bkt_t        bucket_in;
    bkt_t        bucket_cmd;
    ptr_t        np;
    logic        key_hit;
    logic        span_hit;
    logic        bkt_last;
    logic        full;

    function automatic jtc_result_t make_result(logic [1:0] st, jtc_rec_t rec, logic lst);
        jtc_result_t r;
        r.status         = st;
        r.found_key      = rec.key;
        r.found_source   = rec.source;
        r.found_target   = rec.target;
        r.found_backward = rec.backward;
        r.last           = lst;
        return r;
    endfunction

    assign bucket_in  = BKT_W'(cmd.key % 16'(BUCKETS));
    assign bucket_cmd = BKT_W'(cmd_reg.key % 16'(BUCKETS));
    assign np         = (state_reg == S_GET_ENT || state_reg == S_FIND_ENT) ?
                        entry_rd.link : head_ptr;
    assign key_hit    = (entry_rd.rec.key == cmd_reg.key);
    // forward span, or reverse span on a record marked backward
    assign span_hit   = ((cmd_reg.key >= entry_rd.rec.source) &&
                         (cmd_reg.key <= entry_rd.rec.target)) ||
                        ((cmd_reg.key <= entry_rd.rec.source) &&
                         (cmd_reg.key >= entry_rd.rec.target) && entry_rd.rec.backward);
    assign bkt_last   = (bkt_reg == BKT_W'(BUCKETS - 1));
    assign full       = (count_reg >= CNT_W'(CAPACITY));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            bkt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            bkt_reg        <= bkt_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        bkt_next        = bkt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        strobe_next     = 1'b0;
        result_next     = '0;
        head_cmd        = '0;
        entry_cmd       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    unique case (cmd.action)
                        ACT_INSERT:
                        begin
                            if (full)
                            begin
                                strobe_next = 1'b1;
                                result_next = make_result(ST_FULL, '0, 1'b1);
                            end
                            else
                            begin
                                head_cmd.raddr = bucket_in;
                                state_next     = S_INS;
                            end
                        end
                        ACT_GET:
                        begin
                            head_cmd.raddr = bucket_in;
                            state_next     = S_GET_HEAD;
                        end
                        ACT_FIND:
                        begin
                            head_cmd.raddr  = '0;
                            bkt_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_FIND_HEAD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_INS:
            begin
                entry_cmd.we         = 1'b1;
                entry_cmd.waddr      = count_reg[ADDR_W-1:0];
                entry_cmd.wdata.rec  = '{key: cmd_reg.key, source: cmd_reg.jump_source,
                                         target: cmd_reg.jump_target,
                                         backward: cmd_reg.backward};
                entry_cmd.wdata.link = head_ptr;
                head_cmd.we          = 1'b1;
                head_cmd.waddr       = bucket_cmd;
                head_cmd.wdata       = PTR_W'(count_reg);
                count_next           = count_reg + 1'b1;
                strobe_next          = 1'b1;
                result_next          = make_result(ST_OK, '0, 1'b1);
                state_next           = S_IDLE;
            end

            S_GET_HEAD, S_GET_ENT:
            begin
                if (state_reg == S_GET_ENT && key_hit)
                begin
                    strobe_next = 1'b1;
                    result_next = make_result(ST_OK, entry_rd.rec, 1'b1);
                    state_next  = S_IDLE;
                end
                else if (np == NIL)
                begin
                    strobe_next = 1'b1;
                    result_next = make_result(ST_NOMATCH, '0, 1'b1);
                    state_next  = S_IDLE;
                end
                else
                begin
                    entry_cmd.raddr = np[ADDR_W-1:0];
                    state_next      = S_GET_ENT;
                end
            end

            S_FIND_HEAD, S_FIND_ENT:
            begin
                // hold the newest match back one step so the final one can carry last
                if (state_reg == S_FIND_ENT && span_hit)
                begin
                    if (pend_valid_reg)
                    begin
                        strobe_next = 1'b1;
                        result_next = make_result(ST_OK, pend_reg, 1'b0);
                    end
                    pend_next       = entry_rd.rec;
                    pend_valid_next = 1'b1;
                end
                if (np != NIL)
                begin
                    entry_cmd.raddr = np[ADDR_W-1:0];
                    state_next      = S_FIND_ENT;
                end
                else if (bkt_last)
                begin
                    state_next = S_FIND_DONE;
                end
                else
                begin
                    bkt_next       = bkt_reg + 1'b1;
                    head_cmd.raddr = bkt_reg + 1'b1;
                    state_next     = S_FIND_HEAD;
                end
            end

            S_FIND_DONE:
            begin
                strobe_next = 1'b1;
                if (pend_valid_reg)
                begin
                    result_next = make_result(ST_OK, pend_reg, 1'b1);
                end
                else
                begin
                    result_next = make_result(ST_NOMATCH, '0, 1'b1);
                end
                pend_valid_next = 1'b0;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

// ===== design/jump_table_with_cover_query_unit.sv =====
// Top level: hash table of jump records with chained buckets and cover query.
// Insert: the result is registered out of S_INS, or straight from idle when the store is full.
// Get walks the key's bucket chain; find walks every bucket's chain in turn, then S_FIND_DONE.
// Each step waits on one registered head or record RAM read, so walks are serial.
// busy drops as the final result goes out; the next transfer can land that cycle.
// Reset clears head valid bits and the record count at once; no clearing pass.
module jump_table_with_cover_query_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  jtc_pkg::jtc_cmd_t    cmd,
    output logic                 busy,
    output logic                 strobe,
    output jtc_pkg::jtc_result_t result
);
    import jtc_pkg::*;

    head_cmd_t          head_cmd;
    ptr_t               head_ptr;
    entry_cmd_t         entry_cmd;
    logic [ENTRY_W-1:0] entry_raw;
    jtc_entry_t         entry_rd;

    jtc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .head_cmd  (head_cmd),
        .head_ptr  (head_ptr),
        .entry_cmd (entry_cmd),
        .entry_rd  (entry_rd),
        .strobe    (strobe),
        .result    (result)
    );

    jtc_heads u_heads (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .head_ptr (head_ptr)
    );

    jtc_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ENTRY_W)
    ) u_store (
        .clk   (clk),
        .we    (entry_cmd.we),
        .waddr (entry_cmd.waddr),
        .wdata (entry_cmd.wdata),
        .raddr (entry_cmd.raddr),
        .rdata (entry_raw)
    );

    assign entry_rd = jtc_entry_t'(entry_raw);

endmodule

// ===== design/jtc_checker.sv =====
// Port-level checks for the jump table unit, bound to the top level.
module jtc_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input jtc_pkg::jtc_cmd_t    cmd,
    input logic                 busy,
    input logic                 strobe,
    input jtc_pkg::jtc_result_t result
);
    import jtc_pkg::*;

    a_walk_starts: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd.action == ACT_GET || cmd.action == ACT_FIND)
        |=> busy && !strobe)
        else $error("get or find transfer did not start a walk");

    a_unused_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.action == ACT_NONE |=> !busy && !strobe)
        else $error("unused action produced activity");

    a_fail_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.status != ST_OK |-> result.last && result.found_key == 16'd0 &&
        result.found_source == 16'd0 && result.found_target == 16'd0 &&
        !result.found_backward)
        else $error("failure result not final or carries record data");

    a_last_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (busy == !result.last))
        else $error("busy does not track the final result");

endmodule

bind jump_table_with_cover_query_unit jtc_checker u_chk (.*);

// ===== verif/tb_jump_table_with_cover_query_unit.sv =====
// Testbench for the jump table with cover query: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_jump_table_with_cover_query_unit;
    import jtc_pkg::*;

    localparam int HALF_NS    = 2;
    localparam int RAND_ITEMS = 300;
    localparam int DRAIN_CYC  = 120;
    localparam int LIMIT_NS   = 2_000_000;
    localparam int MAX_SHOWN  = 10;

    typedef struct packed {
        jtc_cmd_t    c;
        logic        pinned;
        jtc_result_t want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    jtc_cmd_t    cmd;
    logic        busy;
    logic        strobe;
    jtc_result_t result;

    // fixed answer for a directed row, travels with the command
    logic        pin_valid;
    jtc_result_t pin_res;

    jtc_result_t expected_q[$];
    int          mismatches;

    // shadow copy of the table contents
    ptr_t        shadow_head [BUCKETS];
    jtc_rec_t    shadow_rec  [CAPACITY];
    ptr_t        shadow_link [CAPACITY];
    int          shadow_count;

    logic [15:0] used_keys[$];
    dir_row_t    dir_rows[$];

    jump_table_with_cover_query_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    initial clk = 1'b0;
    always #(HALF_NS) clk = ~clk;

    initial
    begin
        #(LIMIT_NS);
        $display("jump_table_with_cover_query_unit test failed");
        $finish;
    end

    function automatic jtc_result_t rec_result(input jtc_rec_t e);
        jtc_result_t r;
        r.status         = ST_OK;
        r.found_key      = e.key;
        r.found_source   = e.source;
        r.found_target   = e.target;
        r.found_backward = e.backward;
        r.last           = 1'b0;
        return r;
    endfunction

    // Updates the shadow table and queues the results one command causes.
    task automatic predict_table_op(input jtc_cmd_t c, input logic use_pin,
                                    input jtc_result_t pinned);
        jtc_result_t r;
        jtc_result_t hits [CAPACITY];
        int          n;
        int          b;
        int          p;
        int          steps;
        logic        fwd;
        logic        bwd;
        logic        got;
        begin
            r      = '0;
            r.last = 1'b1;
            n      = 0;
            got    = 1'b0;
            case (c.action)
                ACT_INSERT:
                begin
                    if (shadow_count >= CAPACITY)
                        r.status = ST_FULL;
                    else
                    begin
                        b = c.key % BUCKETS;
                        shadow_rec[shadow_count]  = '{c.key, c.jump_source, c.jump_target,
                                                      c.backward};
                        shadow_link[shadow_count] = shadow_head[b];
                        shadow_head[b]            = ptr_t'(shadow_count);
                        shadow_count++;
                        r.status = ST_OK;
                    end
                end
                ACT_GET:
                begin
                    r.status = ST_NOMATCH;
                    p        = int'(shadow_head[c.key % BUCKETS]);
                    steps    = 0;
                    while (!got && steps < CAPACITY && p != NIL && p < shadow_count)
                    begin
                        if (shadow_rec[p].key == c.key)
                        begin
                            got    = 1'b1;
                            r      = rec_result(shadow_rec[p]);
                            r.last = 1'b1;
                        end
                        else
                            p = int'(shadow_link[p]);
                        steps++;
                    end
                end
                ACT_FIND:
                begin
                    for (b = 0; b < BUCKETS; b++)
                    begin
                        p     = int'(shadow_head[b]);
                        steps = 0;
                        while (steps < CAPACITY && p != NIL && p < shadow_count)
                        begin
                            fwd = c.key >= shadow_rec[p].source &&
                                  c.key <= shadow_rec[p].target;
                            bwd = c.key <= shadow_rec[p].source &&
                                  c.key >= shadow_rec[p].target && shadow_rec[p].backward;
                            if ((fwd || bwd) && n < CAPACITY)
                            begin
                                hits[n] = rec_result(shadow_rec[p]);
                                n++;
                            end
                            p = int'(shadow_link[p]);
                            steps++;
                        end
                    end
                    if (n == 0)
                        r.status = ST_NOMATCH;
                end
                default: ;
            endcase

            if (c.action != ACT_NONE)
            begin
                if (use_pin)
                    expected_q.push_back(pinned);
                else if (c.action == ACT_FIND && n > 0)
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        hits[i].last = (i == n - 1);
                        expected_q.push_back(hits[i]);
                    end
                end
                else
                    expected_q.push_back(r);
            end
        end
    endtask

    task automatic check_result(input jtc_result_t got);
        jtc_result_t want;
        begin
            if (expected_q.size() == 0)
            begin
                if (mismatches < MAX_SHOWN)
                    $display("unexpected result: st=%0d key=%h src=%h tgt=%h bwd=%0d last=%0d",
                             got.status, got.found_key, got.found_source,
                             got.found_target, got.found_backward, got.last);
                mismatches++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.status !== want.status || got.found_key !== want.found_key ||
                    got.found_source !== want.found_source ||
                    got.found_target !== want.found_target ||
                    got.found_backward !== want.found_backward || got.last !== want.last)
                begin
                    if (mismatches < MAX_SHOWN)
                        $display("mismatch: want st=%0d key=%h src=%h tgt=%h bwd=%0d last=%0d",
                                 want.status, want.found_key, want.found_source,
                                 want.found_target, want.found_backward, want.last,
                                 " / got st=%0d key=%h src=%h tgt=%h bwd=%0d last=%0d",
                                 got.status, got.found_key, got.found_source,
                                 got.found_target, got.found_backward, got.last);
                    mismatches++;
                end
            end
        end
    endtask

    // Sampled at the rising edge: results first, then the command transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe === 1'b1)
                check_result(result);
            if (start && !busy)
                predict_table_op(cmd, pin_valid, pin_res);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_cmd(input jtc_cmd_t c, input int gap, input logic has_pin,
                            input jtc_result_t pinned);
        begin
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            start     <= 1'b1;
            cmd       <= c;
            pin_valid <= has_pin;
            pin_res   <= pinned;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    task automatic drain_results();
        begin
            start <= 1'b0;
            do
                @(negedge clk);
            while (expected_q.size() != 0);
        end
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] hot_addr();
        case ($urandom_range(0, 4))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return 16'h1234;
        endcase
    endfunction

    function automatic logic [15:0] near(input logic [15:0] base);
        return base + 16'($urandom_range(0, 80)) - 16'd40;
    endfunction

    function automatic dir_row_t mk_row(input logic [1:0] action, input logic [15:0] key,
                                        input logic [15:0] src, input logic [15:0] tgt,
                                        input logic bwd, input logic pinned,
                                        input logic [1:0] status);
        dir_row_t row;
        row.c      = '{action, key, src, tgt, bwd};
        row.pinned = pinned;
        row.want   = '0;
        row.want.status = status;
        row.want.last   = 1'b1;
        return row;
    endfunction

    task automatic make_random_cmd(output jtc_cmd_t c);
        int roll;
        int ins_w;
        int mode;
        int idx;
        begin
            c     = '0;
            roll  = $urandom_range(0, 99);
            ins_w = (shadow_count < CAPACITY) ? 45 : 10;
            if (roll < ins_w)
                c.action = ACT_INSERT;
            else if (roll < ins_w + (95 - ins_w) / 2)
                c.action = ACT_GET;
            else if (roll < 95)
                c.action = ACT_FIND;
            else
                c.action = ACT_NONE;

            // unused fields still carry random bits
            c.jump_source = 16'($urandom);
            c.jump_target = 16'($urandom);
            c.backward    = 1'($urandom_range(0, 1));
            mode          = $urandom_range(0, 99);

            case (c.action)
                ACT_INSERT:
                begin
                    if (mode < 40)
                        c.key = 16'($urandom_range(0, 47));
                    else if (mode < 60 && used_keys.size() > 0)
                        c.key = used_keys[$urandom_range(0, used_keys.size() - 1)];
                    else
                        c.key = 16'($urandom);
                    used_keys.push_back(c.key);
                    mode = $urandom_range(0, 99);
                    if (mode < 12)
                    begin
                        if (c.backward && $urandom_range(0, 1))
                        begin
                            c.jump_source = 16'hFFFF;
                            c.jump_target = 16'h0000;
                        end
                        else
                        begin
                            c.jump_source = 16'h0000;
                            c.jump_target = 16'hFFFF;
                        end
                    end
                    else if (mode < 45)
                        ;
                    else if (mode < 85)
                    begin
                        c.jump_source = hot_addr();
                        c.jump_target = near(c.jump_source);
                        c.jump_source = near(c.jump_source);
                    end
                    else
                    begin
                        c.jump_source = $urandom_range(0, 1) ? hot_addr() : 16'($urandom);
                        c.jump_target = c.jump_source;
                    end
                end
                ACT_GET:
                begin
                    if (mode < 50 && used_keys.size() > 0)
                        c.key = used_keys[$urandom_range(0, used_keys.size() - 1)];
                    else if (mode < 70 && used_keys.size() > 0)
                        c.key = used_keys[$urandom_range(0, used_keys.size() - 1)] ^
                                {12'($urandom_range(1, 4095)), 4'b0000};
                    else
                        c.key = 16'($urandom);
                end
                ACT_FIND:
                begin
                    if (mode < 35)
                        c.key = near(hot_addr());
                    else if (mode < 70 && shadow_count > 0)
                    begin
                        idx   = $urandom_range(0, shadow_count - 1);
                        c.key = $urandom_range(0, 1) ? shadow_rec[idx].source
                                                     : shadow_rec[idx].target;
                        c.key = c.key + 16'($urandom_range(0, 2)) - 16'd1;
                    end
                    else
                        c.key = 16'($urandom);
                end
                default:
                    c.key = 16'($urandom);
            endcase
        end
    endtask

    initial
    begin
        jtc_cmd_t c;

        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        pin_valid    = 1'b0;
        pin_res      = '0;
        mismatches   = 0;
        shadow_count = 0;
        for (int i = 0; i < BUCKETS; i++)
            shadow_head[i] = NIL;

        // empty table, extremes, chains within one bucket, reverse ranges
        dir_rows.push_back(mk_row(ACT_GET,    16'h0000, 16'h0000, 16'h0000, 0, 1, ST_NOMATCH));
        dir_rows.push_back(mk_row(ACT_FIND,   16'h0000, 16'h0000, 16'h0000, 0, 1, ST_NOMATCH));
        dir_rows.push_back(mk_row(ACT_NONE,   16'h1234, 16'hABCD, 16'h5678, 1, 0, ST_OK));
        dir_rows.push_back(mk_row(ACT_INSERT, 16'hFFFF, 16'h0000, 16'hFFFF, 0, 1, ST_OK));
        dir_rows.push_back(mk_row(ACT_INSERT, 16'h000F, 16'h0064, 16'h00C8, 1, 1, ST_OK));
        dir_rows.push_back(mk_row(ACT_INSERT, 16'hFFFF, 16'h012C, 16'h0032, 1, 1, ST_OK));
        dir_rows.push_back(mk_row(ACT_INSERT, 16'h0010, 16'h01F4, 16'h0190, 0, 1, ST_OK));
        dir_rows.push_back(mk_row(ACT_GET,    16'hFFFF, 16'h0000, 16'h0000, 0, 0, ST_OK));
        dir_rows.push_back(mk_row(ACT_GET,    16'h000F, 16'h0000, 16'h0000, 0, 0, ST_OK));
        dir_rows.push_back(mk_row(ACT_GET,    16'h001F, 16'h0000, 16'h0000, 0, 1, ST_NOMATCH));
        dir_rows.push_back(mk_row(ACT_GET,    16'h0010, 16'h0000, 16'h0000, 0, 0, ST_OK));
        dir_rows.push_back(mk_row(ACT_FIND,   16'h0000, 16'h0000, 16'h0000, 0, 0, ST_OK));
        dir_rows.push_back(mk_row(ACT_FIND,   16'h0064, 16'h0000, 16'h0000, 0, 0, ST_OK));
        dir_rows.push_back(mk_row(ACT_FIND,   16'h00C8, 16'h0000, 16'h0000, 0, 0, ST_OK));
        dir_rows.push_back(mk_row(ACT_FIND,   16'h0032, 16'h0000, 16'h0000, 0, 0, ST_OK));
        dir_rows.push_back(mk_row(ACT_FIND,   16'h012C, 16'h0000, 16'h0000, 0, 0, ST_OK));
        dir_rows.push_back(mk_row(ACT_FIND,   16'h01C2, 16'h0000, 16'h0000, 0, 0, ST_OK));
        dir_rows.push_back(mk_row(ACT_FIND,   16'hFFFF, 16'h0000, 16'h0000, 0, 0, ST_OK));
        dir_rows.push_back(mk_row(ACT_NONE,   16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0, ST_OK));
        dir_rows.push_back(mk_row(ACT_INSERT, 16'h0000, 16'hFFFF, 16'hFFFF, 1, 1, ST_OK));
        dir_rows.push_back(mk_row(ACT_FIND,   16'hFFFF, 16'h0000, 16'h0000, 0, 0, ST_OK));
        dir_rows.push_back(mk_row(ACT_GET,    16'h0000, 16'h0000, 16'h0000, 0, 0, ST_OK));
        dir_rows.push_back(mk_row(ACT_FIND,   16'h8000, 16'h0000, 16'h0000, 0, 0, ST_OK));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].c.action == ACT_INSERT)
                used_keys.push_back(dir_rows[i].c.key);
            send_cmd(dir_rows[i].c, pick_gap(), dir_rows[i].pinned, dir_rows[i].want);
        end
        drain_results();

        // random traffic; the table fills part way through, so full inserts follow
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            make_random_cmd(c);
            if (i == RAND_ITEMS / 2)
                drain_results();
            send_cmd(c, (i >= 100 && i < 140) ? 0 : pick_gap(), 1'b0, '0);
        end

        start <= 1'b0;
        do
            @(negedge clk);
        while (expected_q.size() != 0);
        repeat (DRAIN_CYC) @(posedge clk);

        if (mismatches == 0 && expected_q.size() == 0)
            $display("jump_table_with_cover_query_unit test passed");
        else
            $display("jump_table_with_cover_query_unit test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/jtc_pkg.sv
design/jtc_ram.sv
design/jtc_heads.sv
design/jtc_ctrl.sv
design/jump_table_with_cover_query_unit.sv
design/jtc_checker.sv
verif/tb_jump_table_with_cover_query_unit.sv
